// ===== hdl/anfg_pkg.sv =====
// ----------------------------------------------------------------------------
// anfg_pkg
// Shared types, constants and control store for the adaptive noise-floor gate.
// ----------------------------------------------------------------------------
package anfg_pkg;

	localparam int unsigned IN_DATA_W  = 24;
	localparam int unsigned OUT_DATA_W = 40;
	localparam int unsigned CFG_ADDR_W = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_RELEASE_GAIN  = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_FLOOR_GAIN    = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_FLOOR_DRIFT   = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_GATE_MARGIN   = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_HYST_WIDTH    = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_SQUAWK_THR    = 3'd5;
	localparam logic [CFG_ADDR_W-1:0] REG_CRY_THR       = 3'd6;
	localparam logic [CFG_ADDR_W-1:0] REG_INITIAL_FLOOR = 3'd7;

	// register reset values
	localparam logic [15:0]        RST_RELEASE_GAIN  = 16'd6554;
	localparam logic [15:0]        RST_FLOOR_GAIN    = 16'd655;
	localparam logic [7:0]         RST_FLOOR_DRIFT   = 8'd1;
	localparam logic [13:0]        RST_GATE_MARGIN   = 14'd1536;
	localparam logic [12:0]        RST_HYST_WIDTH    = 13'd768;
	localparam logic signed [15:0] RST_SQUAWK_THR    = -16'sd5120;
	localparam logic signed [15:0] RST_CRY_THR       = -16'sd2560;
	localparam logic signed [15:0] RST_INITIAL_FLOOR = -16'sd15360;

	// ceil(2^24 / 10): exact divide by ten for the operand range used
	localparam logic [20:0] RECIP_TEN = 21'd1677722;
	localparam int unsigned RECIP_SHIFT = 24;

	localparam int unsigned STEP_W = 3;
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t S_ACCEPT   = 3'd0;
	localparam step_t S_ENV_MUL  = 3'd1;
	localparam step_t S_ENV_ADD  = 3'd2;
	localparam step_t S_FLR_TEST = 3'd3;
	localparam step_t S_FLR_ADD  = 3'd4;
	localparam step_t S_TENTHS   = 3'd5;
	localparam step_t S_RECIP    = 3'd6;
	localparam step_t S_EMIT     = 3'd7;

	typedef logic [1:0] mul_sel_t;
	localparam mul_sel_t MUL_ENV = 2'd0;
	localparam mul_sel_t MUL_FLR = 2'd1;
	localparam mul_sel_t MUL_RCP = 2'd2;

	typedef logic [1:0] jmp_t;
	localparam jmp_t J_SEQ    = 2'd0;
	localparam jmp_t J_ACCEPT = 2'd1;
	localparam jmp_t J_FLOOR  = 2'd2;
	localparam jmp_t J_EMIT   = 2'd3;

	typedef struct packed {
		logic     in_rdy;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     env_add;
		logic     flr_test;
		logic     flr_add;
		logic     tenths_ld;
		logic     emit;
		jmp_t     jmp;
		step_t    next_step;
		step_t    alt_step;
	} ctrl_t;

	function automatic ctrl_t ucode(step_t s);
		ctrl_t c;
		c = '0;
		unique case (s)
			S_ACCEPT: begin
				c.in_rdy    = 1'b1;
				c.jmp       = J_ACCEPT;
				c.next_step = S_ENV_MUL;
				c.alt_step  = S_FLR_TEST;
			end
			S_ENV_MUL: begin
				c.mul_en    = 1'b1;
				c.mul_sel   = MUL_ENV;
				c.next_step = S_ENV_ADD;
			end
			S_ENV_ADD: begin
				c.env_add   = 1'b1;
				c.next_step = S_FLR_TEST;
			end
			S_FLR_TEST: begin
				c.mul_en    = 1'b1;
				c.mul_sel   = MUL_FLR;
				c.flr_test  = 1'b1;
				c.jmp       = J_FLOOR;
				c.next_step = S_FLR_ADD;
				c.alt_step  = S_TENTHS;
			end
			S_FLR_ADD: begin
				c.flr_add   = 1'b1;
				c.next_step = S_TENTHS;
			end
			S_TENTHS: begin
				c.tenths_ld = 1'b1;
				c.next_step = S_RECIP;
			end
			S_RECIP: begin
				c.mul_en    = 1'b1;
				c.mul_sel   = MUL_RCP;
				c.next_step = S_EMIT;
			end
			S_EMIT: begin
				c.emit      = 1'b1;
				c.jmp       = J_EMIT;
				c.next_step = S_ACCEPT;
			end
		endcase
		return c;
	endfunction

endpackage

// ===== hdl/adaptive_noise_floor_gate.sv =====
// ----------------------------------------------------------------------------
// adaptive_noise_floor_gate
// Envelope follower with adaptive noise floor, gated level and two
// hysteresis flags, run by a small microcoded sequencer.
// ----------------------------------------------------------------------------
// One input transfer is one meter tick. For a live tick (enabled, peak present)
// the control store steps through envelope release, floor update and the 0.1
// dB rounding on one shared 20x22 multiplier, skipping the release steps on an
// attack and the floor add while the floor drifts. A disabled or absent tick
// goes straight from the accepting step to the emit step. Either way the result
// is registered into the output register at the emit step. A new tick is taken
// while the previous result is still waiting in the output register; the
// sequencer only holds at its last step when that register is still full.
// Writing initial_floor reloads the floor unless a floor update lands in the
// same cycle.
module adaptive_noise_floor_gate (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// peak_level [15:0], audio_enabled [16], zero [23:17]
	input  logic [anfg_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// peak_present
	input  logic                                s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// gated_level [15:0], floor_level [31:16], squawk_active [32],
	// cry_active [33], zero [39:34]
	output logic [anfg_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	// level_valid
	output logic                                m_axis_tuser,
	input  logic                                cfg_wen,
	input  logic [anfg_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [anfg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import anfg_pkg::*;

	// configuration
	logic [15:0]        rel_gain_q;
	logic [15:0]        flr_gain_q;
	logic [7:0]         drift_q;
	logic [13:0]        margin_q;
	logic [12:0]        hyst_q;
	logic signed [15:0] sq_thr_q;
	logic signed [15:0] cry_thr_q;

	// state
	step_t              pc_q;
	logic signed [15:0] env_q;
	logic               seeded_q;
	logic signed [15:0] floor_q;
	logic               sq_q;
	logic               cry_q;
	logic               en_q;
	logic               pr_q;
	logic               ev_q;
	logic               m_valid_q;

	// datapath
	logic signed [15:0] v_q;
	logic signed [41:0] p_q;
	logic [18:0]        tm_q;
	logic               neg_q;
	logic [15:0]        m_gated_q;
	logic [15:0]        m_floor_q;
	logic               m_sq_q;
	logic               m_cry_q;
	logic               m_lv_q;

	ctrl_t              cw;
	logic               in_fire;
	logic signed [15:0] in_peak;
	logic               in_en;
	logic               in_pr;
	logic               env_load;
	logic               out_free;
	logic               sq_nxt;
	logic               cry_nxt;

	logic signed [16:0] diff_env;
	logic signed [16:0] diff_flr;
	logic signed [19:0] mul_a;
	logic signed [21:0] mul_b;
	logic signed [41:0] mul_p;

	logic [41:0]        p_mag;
	logic [33:0]        p_rnd;
	logic [17:0]        r_mag;
	logic signed [17:0] delta;
	logic signed [17:0] env_sum;
	logic signed [17:0] flr_sum;
	logic signed [16:0] drift_sum;
	logic signed [15:0] drift_sat;
	logic signed [17:0] flr_lim;
	logic               above;

	logic [15:0]        env_abs;
	logic [18:0]        n_abs;
	logic [18:0]        n_rnd;
	logic [18:0]        tm_nxt;
	logic [16:0]        q_ev;
	logic [15:0]        gated_ev;
	logic [15:0]        flr_abs;
	logic [16:0]        f_rnd;
	logic [16:0]        f_val;
	logic [15:0]        gated_qt;
	logic [15:0]        gated;

	function automatic logic hyst_next(logic signed [15:0] v, logic signed [15:0] thr,
			logic [12:0] hw, logic st);
		logic signed [17:0] lo;
		lo = 18'(thr) - $signed({5'b0, hw});
		if (st)
			return 18'(v) > lo;
		return v >= thr;
	endfunction

	assign cw            = ucode(pc_q);
	assign s_axis_tready = cw.in_rdy;
	assign in_fire       = s_axis_tvalid & cw.in_rdy;
	assign in_peak       = $signed(s_axis_tdata[15:0]);
	assign in_en         = s_axis_tdata[16];
	assign in_pr         = s_axis_tuser;
	assign env_load      = !seeded_q || (in_peak > env_q);
	assign out_free      = !m_valid_q || m_axis_tready;
	assign sq_nxt        = hyst_next(in_peak, sq_thr_q, hyst_q, sq_q);
	assign cry_nxt       = hyst_next(in_peak, cry_thr_q, hyst_q, cry_q);

	// shared multiplier
	assign diff_env = 17'(v_q) - 17'(env_q);
	assign diff_flr = 17'(env_q) - 17'(floor_q);

	always_comb begin
		unique case (cw.mul_sel)
			MUL_ENV: begin
				mul_a = $signed({4'b0, rel_gain_q});
				mul_b = 22'(diff_env);
			end
			MUL_FLR: begin
				mul_a = $signed({4'b0, flr_gain_q});
				mul_b = 22'(diff_flr);
			end
			MUL_RCP: begin
				mul_a = $signed({1'b0, tm_q});
				mul_b = $signed({1'b0, RECIP_TEN});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// product / 65536, to nearest, ties away from zero
	assign p_mag   = p_q[41] ? 42'(-p_q) : 42'(p_q);
	assign p_rnd   = p_mag[33:0] + 34'd32768;
	assign r_mag   = p_rnd[33:16];
	assign delta   = p_q[41] ? -$signed(r_mag) : $signed(r_mag);
	assign env_sum = 18'(env_q) + delta;
	assign flr_sum = 18'(floor_q) + delta;

	assign drift_sum = 17'(floor_q) + $signed({9'b0, drift_q});
	assign drift_sat = (drift_sum[16:15] == 2'b01) ? 16'sh7FFF : drift_sum[15:0];

	assign flr_lim = 18'(floor_q) + $signed({4'b0, margin_q});
	assign above   = 18'(env_q) > flr_lim;

	// event rounding: tenths of a dB, on magnitudes
	assign env_abs = env_q[15] ? 16'(-env_q) : env_q;
	assign n_abs   = {env_abs, 3'b0} + {2'b0, env_abs, 1'b0};
	assign n_rnd   = n_abs + 19'd128;
	assign tm_nxt  = {n_rnd[18:8], 8'b0} + 19'd5;
	assign q_ev    = p_q[RECIP_SHIFT+16:RECIP_SHIFT];

	always_comb begin
		if (neg_q)
			gated_ev = 16'(-q_ev[15:0]);
		else if (q_ev[16] || q_ev[15])
			gated_ev = 16'h7FFF;
		else
			gated_ev = q_ev[15:0];
	end

	// quiet rounding: half a dB
	assign flr_abs = floor_q[15] ? 16'(-floor_q) : floor_q;
	assign f_rnd   = {1'b0, flr_abs} + 17'd64;
	assign f_val   = {f_rnd[16:7], 7'b0};

	always_comb begin
		if (floor_q[15])
			gated_qt = 16'(-f_val[15:0]);
		else if (f_val[16] || f_val[15])
			gated_qt = 16'h7FFF;
		else
			gated_qt = f_val[15:0];
	end

	assign gated = ev_q ? gated_ev : gated_qt;

	// sequencer and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rel_gain_q <= RST_RELEASE_GAIN;
			flr_gain_q <= RST_FLOOR_GAIN;
			drift_q    <= RST_FLOOR_DRIFT;
			margin_q   <= RST_GATE_MARGIN;
			hyst_q     <= RST_HYST_WIDTH;
			sq_thr_q   <= RST_SQUAWK_THR;
			cry_thr_q  <= RST_CRY_THR;
			pc_q       <= S_ACCEPT;
			env_q      <= '0;
			seeded_q   <= 1'b0;
			floor_q    <= RST_INITIAL_FLOOR;
			sq_q       <= 1'b0;
			cry_q      <= 1'b0;
			en_q       <= 1'b0;
			pr_q       <= 1'b0;
			ev_q       <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			if (cfg_wen) begin
				unique case (cfg_addr)
					REG_RELEASE_GAIN:  rel_gain_q <= cfg_wdata;
					REG_FLOOR_GAIN:    flr_gain_q <= cfg_wdata;
					REG_FLOOR_DRIFT:   drift_q    <= cfg_wdata[7:0];
					REG_GATE_MARGIN:   margin_q   <= cfg_wdata[13:0];
					REG_HYST_WIDTH:    hyst_q     <= cfg_wdata[12:0];
					REG_SQUAWK_THR:    sq_thr_q   <= $signed(cfg_wdata);
					REG_CRY_THR:       cry_thr_q  <= $signed(cfg_wdata);
					REG_INITIAL_FLOOR: floor_q    <= $signed(cfg_wdata);
				endcase
			end

			if (in_fire) begin
				en_q <= in_en;
				pr_q <= in_pr;
				if (in_en && in_pr) begin
					sq_q     <= sq_nxt;
					cry_q    <= cry_nxt;
					seeded_q <= 1'b1;
					if (env_load)
						env_q <= in_peak;
				end
			end

			if (cw.env_add)
				env_q <= env_sum[15:0];
			if (cw.flr_test && above)
				floor_q <= drift_sat;
			if (cw.flr_add)
				floor_q <= flr_sum[15:0];
			if (cw.tenths_ld)
				ev_q <= above;

			if (cw.emit && out_free)
				m_valid_q <= 1'b1;
			else if (m_axis_tready)
				m_valid_q <= 1'b0;

			unique case (cw.jmp)
				J_SEQ: pc_q <= cw.next_step;
				J_ACCEPT: begin
					if (in_fire) begin
						if (!(in_en && in_pr))
							pc_q <= S_EMIT;
						else if (env_load)
							pc_q <= cw.alt_step;
						else
							pc_q <= cw.next_step;
					end
				end
				J_FLOOR: pc_q <= above ? cw.alt_step : cw.next_step;
				J_EMIT: begin
					if (out_free)
						pc_q <= cw.next_step;
				end
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_fire)
			v_q <= in_peak;
		if (cw.mul_en)
			p_q <= mul_p;
		if (cw.tenths_ld) begin
			tm_q  <= tm_nxt;
			neg_q <= env_q[15];
		end
		if (cw.emit && out_free) begin
			if (!en_q) begin
				m_gated_q <= '0;
				m_floor_q <= '0;
				m_sq_q    <= 1'b0;
				m_cry_q   <= 1'b0;
				m_lv_q    <= 1'b0;
			end else if (!pr_q) begin
				m_gated_q <= '0;
				m_floor_q <= '0;
				m_sq_q    <= sq_q;
				m_cry_q   <= cry_q;
				m_lv_q    <= 1'b0;
			end else begin
				m_gated_q <= gated;
				m_floor_q <= floor_q;
				m_sq_q    <= sq_q;
				m_cry_q   <= cry_q;
				m_lv_q    <= 1'b1;
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {6'b0, m_cry_q, m_sq_q, m_floor_q, m_gated_q};
	assign m_axis_tuser  = m_lv_q;

endmodule
